// ===== design/rci_pkg.sv =====
package rci_pkg;

    // q16.16 value and its wide working form
    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] wide_t;

    localparam q_t Q_ONE = 32'sh0001_0000;
    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // discriminant magnitude, square root and divider geometry
    localparam int RAD_W    = 34;
    localparam int SQ_IN_W  = RAD_W + 16;
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_NW   = 50;
    localparam int DIV_DW   = 33;
    localparam int DIV_QB   = 31;
    localparam int DIV_LAT  = DIV_QB + 2;

    typedef struct packed {
        q_t ox;
        q_t oy;
        q_t oz;
        q_t dx;
        q_t dy;
        q_t dz;
    } ray_t;

    // item handed from the setup front to the solve back
    typedef struct packed {
        ray_t             ray;
        q_t               a;
        q_t               b;
        logic [RAD_W-1:0] rad;
        logic             side_ok;
    } mid_t;

    typedef struct packed {
        logic hit;
        q_t   px;
        q_t   py;
        q_t   pz;
        q_t   nx;
        q_t   ny;
        q_t   nz;
    } res_t;

    function automatic wide_t wx(input q_t v);
        return 64'(v);
    endfunction

    function automatic q_t sat_q(input wide_t v);
        q_t r;
        if (v > wx(Q_MAX))
            r = Q_MAX;
        else if (v < wx(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor of a product over 2^16, saturated
    function automatic q_t mul_q(input wide_t p);
        wide_t sh;
        sh = p >>> 16;
        return sat_q(sh);
    endfunction

endpackage

// ===== design/rci_fifo.sv =====
module rci_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             dv_reg, dv_next;
    logic [WIDTH-1:0] dout_reg;
    logic             load;

    // refill the output register when it is free or being taken
    assign load = (cnt_reg != '0) && (!dv_reg || pop);

    // pointers wrap at the last entry so any depth works
    always_comb
    begin
        if (push)
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        else
            wptr_next = wptr_reg;
        if (load)
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        else
            rptr_next = rptr_reg;
        cnt_next  = cnt_reg + (AW+1)'(push) - (AW+1)'(load);
        if (load)
            dv_next = 1'b1;
        else if (pop)
            dv_next = 1'b0;
        else
            dv_next = dv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
            dv_reg   <= 1'b0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
            dv_reg   <= dv_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= din;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (load)
            dout_reg <= mem[rptr_reg];
    end

    assign dout  = dout_reg;
    assign empty = !dv_reg;

endmodule

// ===== design/rci_sqrt.sv =====
module rci_sqrt (
    input  logic                        clk,
    input  logic [rci_pkg::SQ_IN_W-1:0] rad,
    output logic [rci_pkg::ROOT_W-1:0]  root
);
    import rci_pkg::*;

    localparam int RW = ROOT_W + 4;

    logic [SQ_IN_W-1:0] x_reg    [ROOT_W];
    logic [RW-1:0]      rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];

    // one result bit per stage, two radicand bits consumed each
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [SQ_IN_W-1:0] x_in;
        logic [RW-1:0]      rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [RW-1:0]      rem_sh;
        logic [RW-1:0]      trial;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign x_in    = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-3:0], x_in[2*(ROOT_W-1-k)+1 -: 2]};
        assign trial  = RW'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            x_reg[k]    <= x_in;
            rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
            root_reg[k] <= {root_in[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== design/rci_div.sv =====
module rci_div (
    input  logic                              clk,
    input  logic signed [rci_pkg::DIV_NW-1:0] num,
    input  logic signed [rci_pkg::DIV_DW-1:0] den,
    output rci_pkg::q_t                       quo
);
    import rci_pkg::*;

    localparam int NST = DIV_QB + 1;

    logic [DIV_NW-1:0] nmag;
    logic [DIV_DW-1:0] dabs;

    logic [31:0]       rem_reg  [NST];
    logic [DIV_QB-1:0] q_reg    [NST];
    logic [DIV_QB-1:0] low_reg  [NST];
    logic [31:0]       dmag_reg [NST];
    logic              neg_reg  [NST];
    logic              ovf_reg  [NST];
    q_t                quo_reg;
    logic [31:0]       q32;

    // magnitudes, sign and overflow of the truncated quotient
    assign nmag = num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
    assign dabs = den[DIV_DW-1] ? DIV_DW'(-den) : DIV_DW'(den);

    always_ff @(posedge clk)
    begin
        neg_reg[0]  <= num[DIV_NW-1] ^ den[DIV_DW-1];
        dmag_reg[0] <= dabs[31:0];
        ovf_reg[0]  <= 32'(nmag[DIV_NW-1:DIV_QB]) >= dabs[31:0];
        rem_reg[0]  <= 32'(nmag[DIV_NW-1:DIV_QB]);
        low_reg[0]  <= nmag[DIV_QB-1:0];
        q_reg[0]    <= '0;
    end

    // restoring steps, one quotient bit each
    for (genvar j = 1; j < NST; j++)
    begin : g_step
        logic [32:0] rem2;
        logic        ge;

        assign rem2 = {rem_reg[j-1], low_reg[j-1][DIV_QB-j]};
        assign ge   = rem2 >= {1'b0, dmag_reg[j-1]};

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? 32'(rem2 - {1'b0, dmag_reg[j-1]}) : rem2[31:0];
            q_reg[j]    <= {q_reg[j-1][DIV_QB-2:0], ge};
            low_reg[j]  <= low_reg[j-1];
            dmag_reg[j] <= dmag_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
        end
    end

    assign q32 = {1'b0, q_reg[NST-1]};

    // sign and saturation
    always_ff @(posedge clk)
    begin
        if (ovf_reg[NST-1])
            quo_reg <= neg_reg[NST-1] ? Q_MIN : Q_MAX;
        else
            quo_reg <= neg_reg[NST-1] ? q_t'(-q32) : q_t'(q32);
    end

    assign quo = quo_reg;

endmodule

// ===== design/rci_front.sv =====
module rci_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  rci_pkg::ray_t in_ray,
    output logic          out_valid,
    output rci_pkg::mid_t out_item
);
    import rci_pkg::*;

    logic [5:0] v_reg, v_next;

    ray_t  ray0_reg, ray1_reg, ray2_reg, ray3_reg, ray4_reg;
    wide_t p_xx_reg, p_yy_reg, p_xd_reg, p_yd_reg, p_ex_reg, p_ey_reg;
    q_t    m_xx_reg, m_yy_reg, m_xd_reg, m_yd_reg, m_ex_reg, m_ey_reg;
    q_t    a3_reg, b3_reg, c3_reg, a4_reg, b4_reg;
    wide_t bb_reg, ac_reg;
    wide_t disc;
    logic  side_ok;
    mid_t  item_next, item_reg;

    // stage valids
    assign v_next = {v_reg[4:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // discriminant sign and side gating
    always_comb
    begin
        disc      = wx(mul_q(bb_reg)) - (wx(mul_q(ac_reg)) <<< 2);
        side_ok   = (a4_reg != '0) && !disc[63];
        item_next.ray     = ray4_reg;
        item_next.a       = a4_reg;
        item_next.b       = b4_reg;
        item_next.rad     = side_ok ? disc[RAD_W-1:0] : '0;
        item_next.side_ok = side_ok;
    end

    // quadratic setup pipeline
    always_ff @(posedge clk)
    begin
        ray0_reg <= in_ray;

        ray1_reg <= ray0_reg;
        p_xx_reg <= wx(ray0_reg.dx) * wx(ray0_reg.dx);
        p_yy_reg <= wx(ray0_reg.dy) * wx(ray0_reg.dy);
        p_xd_reg <= wx(ray0_reg.ox) * wx(ray0_reg.dx);
        p_yd_reg <= wx(ray0_reg.oy) * wx(ray0_reg.dy);
        p_ex_reg <= wx(ray0_reg.ox) * wx(ray0_reg.ox);
        p_ey_reg <= wx(ray0_reg.oy) * wx(ray0_reg.oy);

        ray2_reg <= ray1_reg;
        m_xx_reg <= mul_q(p_xx_reg);
        m_yy_reg <= mul_q(p_yy_reg);
        m_xd_reg <= mul_q(p_xd_reg);
        m_yd_reg <= mul_q(p_yd_reg);
        m_ex_reg <= mul_q(p_ex_reg);
        m_ey_reg <= mul_q(p_ey_reg);

        ray3_reg <= ray2_reg;
        a3_reg   <= sat_q(wx(m_xx_reg) + wx(m_yy_reg));
        b3_reg   <= sat_q((wx(m_xd_reg) + wx(m_yd_reg)) <<< 1);
        c3_reg   <= sat_q(wx(m_ex_reg) + wx(m_ey_reg) - wx(Q_ONE));

        ray4_reg <= ray3_reg;
        a4_reg   <= a3_reg;
        b4_reg   <= b3_reg;
        bb_reg   <= wx(b3_reg) * wx(b3_reg);
        ac_reg   <= wx(a3_reg) * wx(c3_reg);

        item_reg <= item_next;
    end

    assign out_valid = v_reg[5];
    assign out_item  = item_reg;

endmodule

// ===== design/rci_back.sv =====
module rci_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mid_empty,
    input  rci_pkg::mid_t mid_item,
    input  logic          issue_ok,
    output logic          take,
    output logic          res_valid,
    output rci_pkg::res_t res
);
    import rci_pkg::*;

    typedef struct packed {
        ray_t ray;
        logic side_ok;
    } dv_pay_t;

    logic    b0_v_reg;
    mid_t    b0_reg;
    logic [SQRT_LAT-1:0] sq_v_reg;
    mid_t    sq_dl_reg [SQRT_LAT];
    logic [DIV_LAT-1:0]  dv_v_reg;
    dv_pay_t dv_dl_reg [DIV_LAT];

    logic [ROOT_W-1:0] root;
    mid_t              sm;
    wide_t             nb, s64;
    logic signed [DIV_NW-1:0] num_w [4];
    logic signed [DIV_DW-1:0] den_w [4];
    q_t                t_w [4];

    logic  p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    ray_t  p1_ray_reg, p2_ray_reg;
    logic  p1_ok_reg, p2_ok_reg, p3_ok_reg;
    logic  p3_dz_reg;
    q_t    p1_t_reg [4];
    q_t    p2_t_reg [4];
    q_t    p3_t_reg [4];
    q_t    p4_t_reg [4];
    wide_t p1_prod_reg [4][3];
    q_t    p2_pt_reg [4][3];
    q_t    p3_pt_reg [4][3];
    q_t    p4_pt_reg [4][3];
    wide_t p3_sq_reg [2][2];
    logic  p3_zin_reg [2];
    logic [3:0] p4_ok_reg;
    logic [3:0] cand_ok;
    res_t  res_next, res_reg;
    logic  best_v;
    q_t    best_t;
    logic [1:0] best_i;

    assign take = !mid_empty && issue_ok;

    // valid tracking along the solve pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg <= 1'b0;
            sq_v_reg <= '0;
            dv_v_reg <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end
        else
        begin
            b0_v_reg <= take;
            sq_v_reg <= {sq_v_reg[SQRT_LAT-2:0], b0_v_reg};
            dv_v_reg <= {dv_v_reg[DIV_LAT-2:0], sq_v_reg[SQRT_LAT-1]};
            p1_v_reg <= dv_v_reg[DIV_LAT-1];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    // square root of the discriminant
    rci_sqrt u_sqrt (
        .clk  (clk),
        .rad  ({b0_reg.rad, 16'b0}),
        .root (root)
    );

    // payload delay lines matched to the sqrt and divider latency
    always_ff @(posedge clk)
    begin
        b0_reg       <= mid_item;
        sq_dl_reg[0] <= b0_reg;
        for (int k = 1; k < SQRT_LAT; k++)
            sq_dl_reg[k] <= sq_dl_reg[k-1];
        dv_dl_reg[0].ray     <= sm.ray;
        dv_dl_reg[0].side_ok <= sm.side_ok;
        for (int k = 1; k < DIV_LAT; k++)
            dv_dl_reg[k] <= dv_dl_reg[k-1];
    end

    // numerators and divisors for both roots and both caps
    always_comb
    begin
        sm  = sq_dl_reg[SQRT_LAT-1];
        nb  = -wx(sm.b);
        s64 = 64'(root);
        num_w[0] = DIV_NW'((nb - s64) <<< 16);
        num_w[1] = DIV_NW'((nb + s64) <<< 16);
        num_w[2] = DIV_NW'((wx(Q_ONE) - wx(sm.ray.oz)) <<< 16);
        num_w[3] = DIV_NW'((-wx(Q_ONE) - wx(sm.ray.oz)) <<< 16);
        den_w[0] = DIV_DW'(wx(sm.a) <<< 1);
        den_w[1] = DIV_DW'(wx(sm.a) <<< 1);
        den_w[2] = DIV_DW'(sm.ray.dz);
        den_w[3] = DIV_DW'(sm.ray.dz);
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_div
        rci_div u_div (
            .clk (clk),
            .num (num_w[c]),
            .den (den_w[c]),
            .quo (t_w[c])
        );
    end

    // candidate validity from the registered checks
    always_comb
    begin
        cand_ok[0] = p3_ok_reg && !p3_t_reg[0][31] && p3_zin_reg[0];
        cand_ok[1] = p3_ok_reg && !p3_t_reg[1][31] && p3_zin_reg[1];
        cand_ok[2] = p3_dz_reg && !p3_t_reg[2][31] &&
                     (wx(mul_q(p3_sq_reg[0][0])) + wx(mul_q(p3_sq_reg[0][1])) <= wx(Q_ONE));
        cand_ok[3] = p3_dz_reg && !p3_t_reg[3][31] &&
                     (wx(mul_q(p3_sq_reg[1][0])) + wx(mul_q(p3_sq_reg[1][1])) <= wx(Q_ONE));
    end

    // hit points, cap disk test and in-range test
    always_ff @(posedge clk)
    begin
        p1_ray_reg <= dv_dl_reg[DIV_LAT-1].ray;
        p1_ok_reg  <= dv_dl_reg[DIV_LAT-1].side_ok;
        for (int c = 0; c < 4; c++)
        begin
            p1_t_reg[c]       <= t_w[c];
            p1_prod_reg[c][0] <= wx(t_w[c]) * wx(dv_dl_reg[DIV_LAT-1].ray.dx);
            p1_prod_reg[c][1] <= wx(t_w[c]) * wx(dv_dl_reg[DIV_LAT-1].ray.dy);
            p1_prod_reg[c][2] <= wx(t_w[c]) * wx(dv_dl_reg[DIV_LAT-1].ray.dz);
        end

        p2_ray_reg <= p1_ray_reg;
        p2_ok_reg  <= p1_ok_reg;
        for (int c = 0; c < 4; c++)
        begin
            p2_t_reg[c]     <= p1_t_reg[c];
            p2_pt_reg[c][0] <= sat_q(wx(p1_ray_reg.ox) + wx(mul_q(p1_prod_reg[c][0])));
            p2_pt_reg[c][1] <= sat_q(wx(p1_ray_reg.oy) + wx(mul_q(p1_prod_reg[c][1])));
            p2_pt_reg[c][2] <= sat_q(wx(p1_ray_reg.oz) + wx(mul_q(p1_prod_reg[c][2])));
        end

        p3_ok_reg <= p2_ok_reg;
        p3_dz_reg <= p2_ray_reg.dz != '0;
        for (int c = 0; c < 4; c++)
        begin
            p3_t_reg[c] <= p2_t_reg[c];
            for (int i = 0; i < 3; i++)
                p3_pt_reg[c][i] <= p2_pt_reg[c][i];
        end
        for (int c = 0; c < 2; c++)
        begin
            p3_zin_reg[c]   <= (p2_pt_reg[c][2] > -Q_ONE) && (p2_pt_reg[c][2] < Q_ONE);
            p3_sq_reg[c][0] <= wx(p2_pt_reg[c+2][0]) * wx(p2_pt_reg[c+2][0]);
            p3_sq_reg[c][1] <= wx(p2_pt_reg[c+2][1]) * wx(p2_pt_reg[c+2][1]);
        end

        p4_ok_reg <= cand_ok;
        for (int c = 0; c < 4; c++)
        begin
            p4_t_reg[c] <= p3_t_reg[c];
            for (int i = 0; i < 3; i++)
                p4_pt_reg[c][i] <= p3_pt_reg[c][i];
        end

        res_reg <= res_next;
    end

    // nearest candidate, earlier one wins a tie
    always_comb
    begin
        best_v = 1'b0;
        best_t = '0;
        best_i = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (p4_ok_reg[c] && (!best_v || (p4_t_reg[c] < best_t)))
            begin
                best_v = 1'b1;
                best_t = p4_t_reg[c];
                best_i = 2'(c);
            end
        end
        res_next = '0;
        if (best_v)
        begin
            res_next.hit = 1'b1;
            res_next.px  = p4_pt_reg[best_i][0];
            res_next.py  = p4_pt_reg[best_i][1];
            res_next.pz  = p4_pt_reg[best_i][2];
            if (!best_i[1])
            begin
                res_next.nx = p4_pt_reg[best_i][0];
                res_next.ny = p4_pt_reg[best_i][1];
            end
            else
                res_next.nz = best_i[0] ? -Q_ONE : Q_ONE;
        end
    end

    assign res_valid = p5_v_reg;
    assign res       = res_reg;

endmodule

// ===== design/ray_cylinder_intersect.sv =====
// channel   direction  handshake            payload
// ray       in         push / full          origin_x/y/z, dir_x/y/z
// result    out        pop / empty          hit, point_x/y/z, normal_x/y/z
//
// one ray per cycle is taken while full is low and one result per cycle is delivered while empty is low and pop is high
// a ray's result passes 6 setup stages, the mid queue, then 25 square-root stages,
// 33 divider stages and 5 point/select stages
// full rises when MID_DEPTH rays sit in the setup stages and mid queue
// the solve side only starts a ray with room held for it in the result queue, so
// a stalled pop never stops the pipelines; reset empties both queues at once
module ray_cylinder_intersect #(
    parameter int MID_DEPTH = 16,
    parameter int OUT_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  rci_pkg::q_t origin_x,
    input  rci_pkg::q_t origin_y,
    input  rci_pkg::q_t origin_z,
    input  rci_pkg::q_t dir_x,
    input  rci_pkg::q_t dir_y,
    input  rci_pkg::q_t dir_z,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output rci_pkg::q_t point_x,
    output rci_pkg::q_t point_y,
    output rci_pkg::q_t point_z,
    output rci_pkg::q_t normal_x,
    output rci_pkg::q_t normal_y,
    output rci_pkg::q_t normal_z
);
    import rci_pkg::*;

    localparam int MID_CW = $clog2(MID_DEPTH + 1);
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

    logic              push_xfer, pop_xfer;
    ray_t              in_ray;
    logic              f_valid;
    mid_t              f_item, mid_item;
    logic [$bits(mid_t)-1:0] mid_dout;
    logic              mid_empty;
    logic              take, issue_ok;
    logic              r_valid;
    res_t              r_item, out_res;
    logic [$bits(res_t)-1:0] out_dout;
    logic [MID_CW-1:0] mid_cnt_reg, mid_cnt_next;
    logic [OUT_CW-1:0] out_cnt_reg, out_cnt_next;

    assign push_xfer = push && !full;
    assign pop_xfer  = pop && !empty;

    assign in_ray.ox = origin_x;
    assign in_ray.oy = origin_y;
    assign in_ray.oz = origin_z;
    assign in_ray.dx = dir_x;
    assign in_ray.dy = dir_y;
    assign in_ray.dz = dir_z;

    // credit counts: rays in flight up to each queue
    always_comb
    begin
        mid_cnt_next = mid_cnt_reg + MID_CW'(push_xfer) - MID_CW'(take);
        out_cnt_next = out_cnt_reg + OUT_CW'(take) - OUT_CW'(pop_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_cnt_reg <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            mid_cnt_reg <= mid_cnt_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign full     = mid_cnt_reg == MID_CW'(MID_DEPTH);
    assign issue_ok = out_cnt_reg != OUT_CW'(OUT_DEPTH);

    rci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_xfer),
        .in_ray    (in_ray),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    rci_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(mid_t))
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .din   (f_item),
        .pop   (take),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    assign mid_item = mid_t'(mid_dout);

    rci_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_item),
        .issue_ok  (issue_ok),
        .take      (take),
        .res_valid (r_valid),
        .res       (r_item)
    );

    rci_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(res_t))
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_valid),
        .din   (r_item),
        .pop   (pop_xfer),
        .dout  (out_dout),
        .empty (empty)
    );

    assign out_res  = res_t'(out_dout);
    assign hit      = out_res.hit;
    assign point_x  = out_res.px;
    assign point_y  = out_res.py;
    assign point_z  = out_res.pz;
    assign normal_x = out_res.nx;
    assign normal_y = out_res.ny;
    assign normal_z = out_res.nz;

    // credit never exceeds queue capacity
    a_mid_credit: assert property (@(posedge clk) disable iff (!rst_n)
        mid_cnt_reg <= MID_CW'(MID_DEPTH))
        else $error("mid credit overrun");

    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= OUT_CW'(OUT_DEPTH))
        else $error("result credit overrun");

    // a visible result is always backed by a held credit
    a_res_backed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_cnt_reg != '0))
        else $error("result without credit");

    // the solve side only starts rays that the front produced
    a_take_backed: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (mid_cnt_reg != '0))
        else $error("take without ray");

endmodule
